### rtl/i2cm_pkg.sv
// i2cm_pkg: shared types and constants of the i2c bit-level master
`default_nettype none

package i2cm_pkg;

   // widths fixed by the transaction fields
   localparam int unsigned FUNC_W  = 3;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned PHASE_W = 10;

   // reset value of the phase length register
   localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 10'd10;

   // function codes on the request channel
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

   // classified command
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   // one queued tick
   typedef struct packed {
      cmd_type           cmd;
      logic [BYTE_W-1:0] tx_byte;
      logic              send_ack;
      logic              sda_in;
   } tick_item_type;

   // head of the tick queue as seen by the bus engine
   typedef struct packed {
      logic          valid;
      tick_item_type item;
   } queue_head_type;

   // bus sequence steps
   typedef enum logic [15:0] {
      ST_IDLE      = 16'h0001,
      ST_START0    = 16'h0002,
      ST_START1    = 16'h0004,
      ST_START2    = 16'h0008,
      ST_STOP      = 16'h0010,
      ST_WSET      = 16'h0020,
      ST_WHIGH     = 16'h0040,
      ST_WLOW      = 16'h0080,
      ST_WACKSET   = 16'h0100,
      ST_WACKHIGH  = 16'h0200,
      ST_WACKLOW   = 16'h0400,
      ST_RHIGH     = 16'h0800,
      ST_RLOW      = 16'h1000,
      ST_RACKSET   = 16'h2000,
      ST_RACKHIGH  = 16'h4000,
      ST_RACKLOW   = 16'h8000
   } step_type;

endpackage

`default_nettype wire

### rtl/i2cm_req_if.sv
// i2cm_req_if: request channel carrying one tick and an optional command
`default_nettype none

interface i2cm_req_if;
   logic                           valid;
   logic                           ready;
   logic [i2cm_pkg::FUNC_W-1:0]    func;
   logic [i2cm_pkg::BYTE_W-1:0]    tx_byte;
   logic                           send_ack;
   logic                           sda_in;

   modport source (output valid, output func, output tx_byte, output send_ack,
                   output sda_in, input ready);
   modport sink (input valid, input func, input tx_byte, input send_ack,
                 input sda_in, output ready);
endinterface

`default_nettype wire

### rtl/i2cm_rsp_if.sv
// i2cm_rsp_if: response channel carrying pin levels and status per tick
`default_nettype none

interface i2cm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           scl_level;
   logic                           sda_released;
   logic                           busy_res;
   logic                           done_res;
   logic [i2cm_pkg::BYTE_W-1:0]    rx_byte;
   logic                           ack_missing;
   logic                           cmd_rejected;

   modport source (output valid, output scl_level, output sda_released,
                   output busy_res, output done_res, output rx_byte,
                   output ack_missing, output cmd_rejected, input ready);
   modport sink (input valid, input scl_level, input sda_released,
                 input busy_res, input done_res, input rx_byte,
                 input ack_missing, input cmd_rejected, output ready);
endinterface

`default_nettype wire

### rtl/i2cm_front.sv
// i2cm_front: accepts request transactions, decodes them and queues them
`default_nettype none

module i2cm_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   i2cm_req_if.sink                      req_chan,
   input  wire logic                     pop,
   output i2cm_pkg::queue_head_type      head
);

   localparam int unsigned DEPTH = 2;

   i2cm_pkg::tick_item_type entries_ff [DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        do_pop;
   i2cm_pkg::cmd_type   cmd;
   i2cm_pkg::tick_item_type new_item;

   // decode the function code, unknown codes count as a plain tick
   always_comb begin
      case (req_chan.func)
         i2cm_pkg::FUNC_START: cmd = i2cm_pkg::CMD_START;
         i2cm_pkg::FUNC_STOP:  cmd = i2cm_pkg::CMD_STOP;
         i2cm_pkg::FUNC_WRITE: cmd = i2cm_pkg::CMD_WRITE;
         i2cm_pkg::FUNC_READ:  cmd = i2cm_pkg::CMD_READ;
         default:              cmd = i2cm_pkg::CMD_NONE;
      endcase
      new_item.cmd      = cmd;
      new_item.tx_byte  = req_chan.tx_byte;
      new_item.send_ack = req_chan.send_ack;
      new_item.sda_in   = req_chan.sda_in;
   end

   // queue handshake
   assign req_chan.ready = (count_ff != 2'(DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign do_pop         = pop && (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

### rtl/i2cm_back.sv
// i2cm_back: bus sequencer that runs one queued tick per cycle into the response register while it is not stalled
`default_nettype none

module i2cm_back #(
   parameter int unsigned COUNT_BITS = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [i2cm_pkg::PHASE_W-1:0]      phase_ticks,
   input  wire i2cm_pkg::queue_head_type          head,
   output logic                                   pop,
   i2cm_rsp_if.source                             rsp_chan
);

   localparam int unsigned LW =
      (COUNT_BITS > i2cm_pkg::PHASE_W) ? COUNT_BITS : i2cm_pkg::PHASE_W;

   i2cm_pkg::step_type step_ff, step_in;
   logic [COUNT_BITS-1:0]         pc_ff, pc_in;
   logic [3:0]                    bit_ff, bit_in;
   logic [i2cm_pkg::BYTE_W-1:0]   shift_ff, shift_in;
   logic [i2cm_pkg::BYTE_W-1:0]   rx_ff, rx_in;
   logic                          scl_ff, scl_in;
   logic                          sda_ff, sda_in;
   logic                          ack_ff, ack_in;
   logic                          done_ff, done_in;
   logic                          rej_ff, rej_in;
   logic                          valid_ff, valid_in;

   logic [LW-1:0]                 ticks_ext;
   logic [LW-1:0]                 cmax_ext;
   logic [LW-1:0]                 lim_ext;
   logic [COUNT_BITS-1:0]         lim;
   logic [COUNT_BITS-1:0]         pc_inc;
   logic [3:0]                    bit_inc;
   logic [i2cm_pkg::BYTE_W-1:0]   shift_next;
   logic                          phase_end;
   logic                          advance;
   i2cm_pkg::tick_item_type       item;

   // phase length, zero taken as one and clamped to the counter range
   always_comb begin
      ticks_ext = LW'(phase_ticks);
      cmax_ext  = LW'({COUNT_BITS{1'b1}});
      if (ticks_ext == '0) begin
         lim_ext = LW'(1);
      end else if (ticks_ext > cmax_ext) begin
         lim_ext = cmax_ext;
      end else begin
         lim_ext = ticks_ext;
      end
      lim = COUNT_BITS'(lim_ext);
   end

   // a tick moves when the response register is free or being emptied
   assign advance = head.valid && (!valid_ff || rsp_chan.ready);
   assign pop     = advance;
   assign item    = head.item;

   // sequencer next state
   always_comb begin
      step_in    = step_ff;
      pc_in      = pc_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      rx_in      = rx_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      ack_in     = ack_ff;
      done_in    = 1'b0;
      rej_in     = 1'b0;
      pc_inc     = pc_ff + COUNT_BITS'(1);
      phase_end  = (pc_inc >= lim);
      bit_inc    = bit_ff + 4'd1;
      shift_next = {shift_ff[i2cm_pkg::BYTE_W-2:0], 1'b0};

      if (step_ff != i2cm_pkg::ST_IDLE) begin
         rej_in = (item.cmd != i2cm_pkg::CMD_NONE);
         pc_in  = pc_inc;
         if (phase_end) begin
            pc_in = '0;
            case (step_ff)
               i2cm_pkg::ST_START0: begin
                  step_in = i2cm_pkg::ST_START1;
                  scl_in  = 1'b1;
                  sda_in  = 1'b0;
               end
               i2cm_pkg::ST_START1: begin
                  step_in = i2cm_pkg::ST_START2;
                  scl_in  = 1'b0;
                  sda_in  = 1'b0;
               end
               i2cm_pkg::ST_START2: begin
                  step_in = i2cm_pkg::ST_IDLE;
                  done_in = 1'b1;
               end
               i2cm_pkg::ST_STOP: begin
                  step_in = i2cm_pkg::ST_IDLE;
                  sda_in  = 1'b1;
                  done_in = 1'b1;
               end
               i2cm_pkg::ST_WSET: begin
                  step_in = i2cm_pkg::ST_WHIGH;
                  scl_in  = 1'b1;
               end
               i2cm_pkg::ST_WHIGH: begin
                  step_in = i2cm_pkg::ST_WLOW;
                  scl_in  = 1'b0;
                  if (bit_ff == 4'd7) begin
                     sda_in = 1'b1;
                  end
               end
               i2cm_pkg::ST_WLOW: begin
                  shift_in = shift_next;
                  bit_in   = bit_inc;
                  if (bit_inc[3]) begin
                     step_in = i2cm_pkg::ST_WACKSET;
                     sda_in  = 1'b1;
                  end else begin
                     step_in = i2cm_pkg::ST_WSET;
                     sda_in  = shift_next[i2cm_pkg::BYTE_W-1];
                  end
               end
               i2cm_pkg::ST_WACKSET: begin
                  step_in = i2cm_pkg::ST_WACKHIGH;
                  scl_in  = 1'b1;
               end
               i2cm_pkg::ST_WACKHIGH: begin
                  ack_in  = item.sda_in;
                  step_in = i2cm_pkg::ST_WACKLOW;
                  scl_in  = 1'b0;
                  sda_in  = 1'b1;
               end
               i2cm_pkg::ST_WACKLOW: begin
                  step_in = i2cm_pkg::ST_IDLE;
                  done_in = 1'b1;
               end
               i2cm_pkg::ST_RHIGH: begin
                  rx_in   = {rx_ff[i2cm_pkg::BYTE_W-2:0], item.sda_in};
                  step_in = i2cm_pkg::ST_RLOW;
                  scl_in  = 1'b0;
               end
               i2cm_pkg::ST_RLOW: begin
                  bit_in = bit_inc;
                  if (bit_inc[3]) begin
                     step_in = i2cm_pkg::ST_RACKSET;
                     sda_in  = ~shift_ff[0];
                  end else begin
                     step_in = i2cm_pkg::ST_RHIGH;
                     scl_in  = 1'b1;
                  end
               end
               i2cm_pkg::ST_RACKSET: begin
                  step_in = i2cm_pkg::ST_RACKHIGH;
                  scl_in  = 1'b1;
               end
               i2cm_pkg::ST_RACKHIGH: begin
                  step_in = i2cm_pkg::ST_RACKLOW;
                  scl_in  = 1'b0;
               end
               i2cm_pkg::ST_RACKLOW: begin
                  step_in = i2cm_pkg::ST_IDLE;
                  sda_in  = 1'b1;
                  done_in = 1'b1;
               end
               default: begin
                  step_in = i2cm_pkg::ST_IDLE;
                  done_in = 1'b1;
               end
            endcase
         end
      end else begin
         // idle: start a new command, first phase pins show at once
         case (item.cmd)
            i2cm_pkg::CMD_START: begin
               step_in = i2cm_pkg::ST_START0;
               pc_in   = '0;
               scl_in  = 1'b1;
               sda_in  = 1'b1;
            end
            i2cm_pkg::CMD_STOP: begin
               step_in = i2cm_pkg::ST_STOP;
               pc_in   = '0;
               scl_in  = 1'b1;
               sda_in  = 1'b0;
            end
            i2cm_pkg::CMD_WRITE: begin
               step_in  = i2cm_pkg::ST_WSET;
               pc_in    = '0;
               shift_in = item.tx_byte;
               bit_in   = 4'd0;
               sda_in   = item.tx_byte[i2cm_pkg::BYTE_W-1];
            end
            i2cm_pkg::CMD_READ: begin
               step_in  = i2cm_pkg::ST_RHIGH;
               pc_in    = '0;
               shift_in = {{(i2cm_pkg::BYTE_W-1){1'b0}}, item.send_ack};
               bit_in   = 4'd0;
               rx_in    = '0;
               sda_in   = 1'b1;
               scl_in   = 1'b1;
            end
            default: begin
               step_in = step_ff;
            end
         endcase
      end
   end

   // response valid flag
   always_comb begin
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // sequencer and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= i2cm_pkg::ST_IDLE;
         pc_ff    <= '0;
         bit_ff   <= 4'd0;
         shift_ff <= '0;
         rx_ff    <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
         done_ff  <= 1'b0;
         rej_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            step_ff  <= step_in;
            pc_ff    <= pc_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            rx_ff    <= rx_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            ack_ff   <= ack_in;
            done_ff  <= done_in;
            rej_ff   <= rej_in;
         end
      end
   end

   // response payload comes straight from the state registers
   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.scl_level    = scl_ff;
   assign rsp_chan.sda_released = sda_ff;
   assign rsp_chan.busy_res     = (step_ff != i2cm_pkg::ST_IDLE);
   assign rsp_chan.done_res     = done_ff;
   assign rsp_chan.rx_byte      = rx_ff;
   assign rsp_chan.ack_missing  = ack_ff;
   assign rsp_chan.cmd_rejected = rej_ff;

endmodule

`default_nettype wire

### rtl/i2c_bit_level_master.sv
// i2c_bit_level_master: top level of the tick-driven i2c bit-level master
//
//   channel  | direction | handshake     | carries
//   ---------+-----------+---------------+---------------------------------------
//   req_chan | in        | valid/ready   | func, tx_byte, send_ack, sda_in
//   rsp_chan | out       | valid/ready   | pins, busy, done, rx_byte, ack, reject
//   csr_*    | in        | write enable  | phase_ticks (10 bits)
//
// one request transaction in, one response transaction out; a transaction is
// accepted every cycle while the response side keeps up.
// a request reaches the response through the tick queue, then through the
// sequencer step that loads the response register.
// a two-entry tick queue lets the request side run on while the response stalls.
// reset is synchronous: the queue empties, the bus lines read released.
`default_nettype none

module i2c_bit_level_master #(
   parameter int unsigned COUNT_BITS = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   i2cm_req_if.sink                               req_chan,
   i2cm_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [i2cm_pkg::PHASE_W-1:0]      csr_wr_data
);

   logic [i2cm_pkg::PHASE_W-1:0] phase_ticks_ff;
   logic [i2cm_pkg::PHASE_W-1:0] phase_ticks_in;
   i2cm_pkg::queue_head_type     head;
   logic                         pop;

   // phase length register
   assign phase_ticks_in = csr_wr_en ? csr_wr_data : phase_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cm_pkg::PHASE_TICKS_RESET;
      end else begin
         phase_ticks_ff <= phase_ticks_in;
      end
   end

   // request decode and tick queue
   i2cm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .head     (head)
   );

   // bus sequencer and response register
   i2cm_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .phase_ticks (phase_ticks_ff),
      .head        (head),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

### rtl/i2cm_checker.sv
// i2cm_checker: port-level assertions for the i2c bit-level master and its bind
`default_nettype none

module i2cm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_scl_level,
   input wire logic rsp_sda_released,
   input wire logic rsp_busy_res,
   input wire logic rsp_done_res
);

   // a stalled response stays offered
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid;
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("response dropped while stalled");

   // a stalled response keeps its pin levels
   property p_pins_stable;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> $stable(rsp_scl_level) && $stable(rsp_sda_released);
   endproperty
   a_pins_stable: assert property (p_pins_stable) else $error("pin levels changed while stalled");

   // a finished command leaves the engine idle
   property p_done_idle;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_done_res |-> !rsp_busy_res;
   endproperty
   a_done_idle: assert property (p_done_idle) else $error("done reported while still busy");

   // no response right after reset
   property p_reset_clear;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_clear: assert property (p_reset_clear) else $error("response valid after reset");

endmodule

bind i2c_bit_level_master i2cm_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_scl_level    (rsp_chan.scl_level),
   .rsp_sda_released (rsp_chan.sda_released),
   .rsp_busy_res     (rsp_chan.busy_res),
   .rsp_done_res     (rsp_chan.done_res)
);

`default_nettype wire
